### hdl/deque_with_value_delete_core_assert.svh
// assertion macros for the deque core top level
// depends on a clk and an arst_n signal in the scope of each use
`ifndef DEQUE_WITH_VALUE_DELETE_CORE_ASSERT_SVH
`define DEQUE_WITH_VALUE_DELETE_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define DQVD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DQVD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hdl/dqvd_pkg.sv
// types, sizes and codes of the deque core
// no dependencies
package dqvd_pkg;

	localparam int unsigned DEPTH    = 16;
	localparam int unsigned ENTRY_W  = 32;
	localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
	localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam int unsigned ACTION_W = 3;
	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned STATUS_W = 2;
	localparam int unsigned COUNT_W  = 5;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH_FRONT = 3'd0,
		ACT_PUSH_BACK  = 3'd1,
		ACT_POP_FRONT  = 3'd2,
		ACT_POP_BACK   = 3'd3,
		ACT_DELETE     = 3'd4
	} action_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_FULL     = 2'd2,
		ST_NOTFOUND = 2'd3
	} status_t;

	// operation broadcast to the cells, already gated by transfer and full/empty
	typedef enum logic [2:0] {
		OP_NOP,
		OP_PUSH_FRONT,
		OP_PUSH_BACK,
		OP_POP_FRONT,
		OP_POP_BACK,
		OP_DELETE
	} op_t;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [VALUE_W-1:0]  value;
	} in_item_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  popped_value;
		logic [STATUS_W-1:0] status;
		logic [VALUE_W-1:0]  head_value;
		logic [VALUE_W-1:0]  tail_value;
		logic [COUNT_W-1:0]  entry_count;
	} out_item_t;

	typedef struct packed {
		op_t                op;
		logic [ENTRY_W-1:0] value;
		logic [CNT_W-1:0]   count;
	} cell_ctrl_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] data;
		logic [ENTRY_W-1:0] next_data;
		logic               seen;
		logic [ENTRY_W-1:0] tail_part;
		logic [ENTRY_W-1:0] back_part;
	} cell_out_t;

endpackage

### hdl/dqvd_in_if.sv
// input channel of the deque core: valid/ready with an action and a value
// depends on dqvd_pkg
interface dqvd_in_if import dqvd_pkg::*; ();
	logic     valid;
	logic     ready;
	in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hdl/dqvd_out_if.sv
// result channel of the deque core: valid/ready with one result item
// depends on dqvd_pkg
interface dqvd_out_if import dqvd_pkg::*; ();
	logic      valid;
	logic      ready;
	out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

### hdl/deque_with_value_delete_core.sv
// top level of the deque core: action decode, count, cell row and result register
// depends on dqvd_pkg, dqvd_in_if, dqvd_out_if, dqvd_cell and the assertion header
//
// usage
//   in_ch carries one item per transfer: an action (push front, push back,
//   pop front, pop back, delete first matching value) and a value
//   out_ch gives exactly one result per input item, in order: popped value,
//   status, head and tail entries after the step, and entry count
//   the store is a row of DEPTH cells; every cell compares and shifts in
//   the same cycle, delete included
//   the result is registered and valid the cycle after the input transfer
//   throughput: one item per cycle while the receiver keeps taking results,
//   set by the cell row update and the one-entry result register
//   when the receiver stalls, the result register holds its item and
//   in_ch.ready drops until that result is taken; an item is accepted in the
//   same cycle that the waiting result is taken
//   reset clears the count and the result valid; entry contents are not
//   cleared and are only ever read below the count
module deque_with_value_delete_core import dqvd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	dqvd_in_if.sink     in_ch,
	dqvd_out_if.source  out_ch
);

	`include "deque_with_value_delete_core_assert.svh"

	logic             accept;
	logic             full;
	logic             empty;
	logic             found;
	op_t              op;
	status_t          status;
	cell_ctrl_t       ctrl;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_next;
	logic [ENTRY_W-1:0] tail_next;
	logic [ENTRY_W-1:0] back_val;
	logic [ENTRY_W-1:0] popped;
	logic [ENTRY_W-1:0] head_next;
	cell_out_t        cell_out [DEPTH];
	out_item_t        result_q;
	logic             out_valid_q;

	// result register parts the two sides
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;

	assign full  = count_q == CNT_W'(DEPTH);
	assign empty = count_q == '0;

	// decode; rejected pushes and empty pops become no-ops for the cells
	// a delete miss is flagged at the result register, from the row's match flag
	always_comb begin
		op     = OP_NOP;
		status = ST_OK;
		case (in_ch.data.action)
			ACT_PUSH_FRONT: begin
				if (full) status = ST_FULL;
				else op = OP_PUSH_FRONT;
			end
			ACT_PUSH_BACK: begin
				if (full) status = ST_FULL;
				else op = OP_PUSH_BACK;
			end
			ACT_POP_FRONT: begin
				if (empty) status = ST_EMPTY;
				else op = OP_POP_FRONT;
			end
			ACT_POP_BACK: begin
				if (empty) status = ST_EMPTY;
				else op = OP_POP_BACK;
			end
			ACT_DELETE: begin
				op = OP_DELETE;
			end
			default: begin
				op = OP_NOP;
			end
		endcase
		if (!accept) op = OP_NOP;
	end

	assign ctrl.op    = op;
	assign ctrl.value = ENTRY_W'(in_ch.data.value);
	assign ctrl.count = count_q;

	// cell row, front at index 0; the match flag ripples toward the back
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [ENTRY_W-1:0] left_data;
		logic [ENTRY_W-1:0] right_data;
		logic               seen_in;

		if (i == 0) begin : g_front
			assign left_data = ctrl.value;
			assign seen_in   = 1'b0;
		end else begin : g_mid
			assign left_data = cell_out[i-1].data;
			assign seen_in   = cell_out[i-1].seen;
		end
		if (i == DEPTH - 1) begin : g_back
			assign right_data = '0;
		end else begin : g_inner
			assign right_data = cell_out[i+1].data;
		end

		dqvd_cell u_cell (
			.clk        (clk),
			.pos        (IDX_W'(i)),
			.ctrl       (ctrl),
			.count_next (count_next),
			.left_data  (left_data),
			.right_data (right_data),
			.seen_in    (seen_in),
			.cout       (cell_out[i])
		);
	end

	assign found = cell_out[DEPTH-1].seen;

	always_comb begin
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: count_next = count_q + 1'b1;
			OP_POP_FRONT, OP_POP_BACK:   count_next = count_q - 1'b1;
			OP_DELETE:                   count_next = found ? count_q - 1'b1 : count_q;
			default:                     count_next = count_q;
		endcase
	end

	// only the cell at the new back position and the old back position drive these
	always_comb begin
		tail_next = '0;
		back_val  = '0;
		for (int i = 0; i < DEPTH; i++) begin
			tail_next = tail_next | cell_out[i].tail_part;
			back_val  = back_val | cell_out[i].back_part;
		end
	end

	assign head_next = (count_next == '0) ? '0 : cell_out[0].next_data;

	always_comb begin
		case (op)
			OP_POP_FRONT: popped = cell_out[0].data;
			OP_POP_BACK:  popped = back_val;
			default:      popped = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			if (accept) out_valid_q <= 1'b1;
			else if (out_ch.ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q.popped_value <= VALUE_W'(popped);
			// delete with no match anywhere in the row
			result_q.status       <= (op == OP_DELETE && !found) ? ST_NOTFOUND : status;
			result_q.head_value   <= VALUE_W'(head_next);
			result_q.tail_value   <= VALUE_W'(tail_next);
			result_q.entry_count  <= COUNT_W'(count_next);
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.data  = result_q;

	`DQVD_ASSERT_NOW(a_count_range, 1'b1, count_q <= CNT_W'(DEPTH), "count beyond depth")
	`DQVD_ASSERT_NEXT(a_result_follows, accept, out_valid_q, "no result after transfer")
	`DQVD_ASSERT_NOW(a_count_matches, out_valid_q, result_q.entry_count == COUNT_W'(count_q), "result count differs from store")
	`DQVD_ASSERT_NOW(a_empty_zero, out_valid_q && (count_q == '0), (result_q.head_value == '0) && (result_q.tail_value == '0), "empty store reports entries")
	`DQVD_ASSERT_NEXT(a_pop_shrinks, op == OP_POP_FRONT || op == OP_POP_BACK, count_q == $past(count_q) - 1'b1, "pop did not shrink count")

endmodule

### hdl/dqvd_cell.sv
// one storage cell of the deque row: holds one entry, shifts to or from its neighbors
// depends on dqvd_pkg
module dqvd_cell import dqvd_pkg::*; (
	input  logic               clk,
	input  logic [IDX_W-1:0]   pos,
	input  cell_ctrl_t         ctrl,
	input  logic [CNT_W-1:0]   count_next,
	input  logic [ENTRY_W-1:0] left_data,
	input  logic [ENTRY_W-1:0] right_data,
	input  logic               seen_in,
	output cell_out_t          cout
);

	logic [ENTRY_W-1:0] data_q;
	logic [ENTRY_W-1:0] data_d;
	logic [CNT_W-1:0]   pos_c;
	logic               occupied;
	logic               match;
	logic               seen;

	assign pos_c    = CNT_W'(pos);
	assign occupied = pos_c < ctrl.count;
	assign match    = (ctrl.op == OP_DELETE) && occupied && (data_q == ctrl.value);
	// set from the first match onward
	assign seen     = seen_in | match;

	always_comb begin
		case (ctrl.op)
			OP_PUSH_FRONT: data_d = (pos_c == '0) ? ctrl.value : left_data;
			OP_PUSH_BACK:  data_d = (pos_c == ctrl.count) ? ctrl.value : data_q;
			OP_POP_FRONT:  data_d = right_data;
			OP_DELETE:     data_d = seen ? right_data : data_q;
			default:       data_d = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign cout.data      = data_q;
	assign cout.next_data = data_d;
	assign cout.seen      = seen;
	assign cout.tail_part = ((pos_c + 1'b1) == count_next) ? data_d : '0;
	assign cout.back_part = ((pos_c + 1'b1) == ctrl.count) ? data_q : '0;

endmodule

### test/tb_deque_with_value_delete_core.sv
// self-checking testbench for deque_with_value_delete_core: a scoreboard class
// shadows the deque contents and checks every result against its own prediction
// depends on dqvd_pkg, dqvd_in_if, dqvd_out_if and the core itself
module tb_deque_with_value_delete_core;
	timeunit 1ns;
	timeprecision 1ps;

	import dqvd_pkg::*;

	// action codes the block decodes as no operation
	localparam logic [ACTION_W-1:0] ACT_FIRST_UNUSED = 3'd5;
	localparam logic [ACTION_W-1:0] ACT_LAST_UNUSED  = 3'd7;

	localparam int unsigned REPORT_LIMIT = 10;
	localparam int unsigned DRAIN_CYCLES = 4;

	// shadow of the deque plus the queue of results still owed by the block
	class deque_scoreboard;
		logic [VALUE_W-1:0] held[$];
		out_item_t          due_results[$];
		int unsigned        failures;

		// apply one accepted action to the shadow deque and queue its result
		function void apply_action(in_item_t item);
			out_item_t res;
			int        hit;
			res = '0;
			res.status = ST_OK;
			hit = -1;
			case (item.action)
				ACT_PUSH_FRONT: begin
					if (held.size() >= DEPTH) res.status = ST_FULL;
					else held.push_front(item.value);
				end
				ACT_PUSH_BACK: begin
					if (held.size() >= DEPTH) res.status = ST_FULL;
					else held.push_back(item.value);
				end
				ACT_POP_FRONT: begin
					if (held.size() == 0) res.status = ST_EMPTY;
					else res.popped_value = held.pop_front();
				end
				ACT_POP_BACK: begin
					if (held.size() == 0) res.status = ST_EMPTY;
					else res.popped_value = held.pop_back();
				end
				ACT_DELETE: begin
					// first match from the front, later entries close up
					foreach (held[k])
						if (hit < 0 && held[k] == item.value) hit = k;
					if (hit < 0) res.status = ST_NOTFOUND;
					else held.delete(hit);
				end
				default: ;
			endcase
			if (held.size() != 0) begin
				res.head_value = held[0];
				res.tail_value = held[held.size() - 1];
			end
			res.entry_count = COUNT_W'(held.size());
			due_results.push_back(res);
		endfunction

		function void check_result(out_item_t got);
			out_item_t want;
			if (due_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display("unexpected result: popped %h status %0d head %h tail %h count %0d",
						got.popped_value, got.status, got.head_value, got.tail_value,
						got.entry_count);
				return;
			end
			want = due_results.pop_front();
			if (got.popped_value !== want.popped_value || got.status !== want.status ||
				got.head_value !== want.head_value || got.tail_value !== want.tail_value ||
				got.entry_count !== want.entry_count) begin
				failures++;
				if (failures <= REPORT_LIMIT)
					$display({"result mismatch: popped %h/%h status %0d/%0d head %h/%h",
						" tail %h/%h count %0d/%0d (expected/actual)"},
						want.popped_value, got.popped_value, want.status, got.status,
						want.head_value, got.head_value, want.tail_value, got.tail_value,
						want.entry_count, got.entry_count);
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;

	dqvd_in_if  in_ch ();
	dqvd_out_if out_ch ();

	deque_with_value_delete_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	deque_scoreboard sb = new();

	// idling knobs, changed per phase by the stimulus process
	int unsigned send_idle_pct = 0;
	int unsigned take_stall_pct = 0;
	// long receiver hold-off, counted down by the receiver process
	int unsigned hold_left = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop in case the block hangs
	initial begin
		#2_000_000;
		$display("deque_with_value_delete_core test failed");
		$finish;
	end

	// both channels are sampled at the edge, before any nonblocking update lands
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) sb.apply_action(in_ch.data);
			if (out_ch.valid && out_ch.ready) sb.check_result(out_ch.data);
		end
	end

	// receiver: random stalls per cycle, or a solid hold-off when one is requested
	initial begin
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_left > 0) begin
				out_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= take_stall_pct);
			end
		end
	end

	// offer one item, possibly after idle cycles, and return at its transfer edge;
	// valid stays high so the next item can follow back to back
	task automatic send_item(input logic [ACTION_W-1:0] action,
		input logic [VALUE_W-1:0] value);
		while ($urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid       <= 1'b1;
		in_ch.data.action <= action;
		in_ch.data.value  <= value;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	// hold the input quiet until every owed result has been taken; the first
	// edge lets the scoreboard note the last transfer before the count is read
	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.due_results.size() != 0) @(posedge clk);
	endtask

	// small pool gives duplicates so deletes hit repeated values; extremes and
	// full-width randoms cover every value bit
	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 45) return VALUE_W'($urandom_range(7));
		if (r < 50) return '0;
		if (r < 55) return '1;
		return $urandom;
	endfunction

	// random actions; push_pct steers the fill level toward full or empty
	task automatic send_random(input int unsigned n, input int unsigned push_pct);
		int unsigned        r;
		logic [ACTION_W-1:0] action;
		logic [VALUE_W-1:0]  value;
		repeat (n) begin
			r = $urandom_range(99);
			value = pick_value();
			if (r < 4) begin
				action = ACTION_W'($urandom_range(ACT_FIRST_UNUSED, ACT_LAST_UNUSED));
			end else if (r < 20) begin
				action = ACT_DELETE;
				// mostly aim at a value that is held, somewhere in the row
				if (sb.held.size() != 0 && $urandom_range(99) < 70)
					value = sb.held[$urandom_range(sb.held.size() - 1)];
			end else if ($urandom_range(99) < push_pct) begin
				action = $urandom_range(1) ? ACT_PUSH_BACK : ACT_PUSH_FRONT;
			end else begin
				action = $urandom_range(1) ? ACT_POP_BACK : ACT_POP_FRONT;
			end
			send_item(action, value);
		end
	endtask

	// idle percentages of sender and receiver for each random phase
	int unsigned phase_idle[4]  = '{0, 73, 0, 30};
	int unsigned phase_stall[4] = '{0, 0, 73, 30};
	int unsigned fill_bias[4]   = '{85, 20, 60, 15};

	initial begin
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty store corner cases first
		send_item(ACT_POP_FRONT, '1);
		send_item(ACT_POP_BACK, '0);
		send_item(ACT_DELETE, '0);
		// pushes at both ends with the value extremes and a duplicate
		send_item(ACT_PUSH_BACK, '1);
		send_item(ACT_PUSH_FRONT, '0);
		send_item(ACT_PUSH_BACK, 32'd5);
		send_item(ACT_PUSH_FRONT, 32'd5);
		// delete takes the front copy of the duplicate, then a miss
		send_item(ACT_DELETE, 32'd5);
		send_item(ACT_DELETE, 32'd7);
		// unused codes leave the store alone
		send_item(ACT_FIRST_UNUSED, '1);
		send_item(ACT_LAST_UNUSED, 32'h5555_aaaa);
		// fill to the brim, then push on full at both ends
		while (sb.held.size() + 1 < DEPTH) send_item(ACT_PUSH_BACK, $urandom);
		send_item(ACT_PUSH_FRONT, 32'haaaa_5555);
		send_item(ACT_PUSH_FRONT, 32'd1);
		send_item(ACT_PUSH_BACK, 32'd2);
		send_item(ACT_POP_FRONT, '0);
		send_item(ACT_POP_BACK, '0);
		wait_drained();

		// random phases with different idling, each in fill and drain chunks
		for (int p = 0; p < 4; p++) begin
			send_idle_pct  = phase_idle[p];
			take_stall_pct = phase_stall[p];
			for (int c = 0; c < 4; c++)
				send_random(50, fill_bias[(p + c) % 4]);
			wait_drained();
		end

		// back-pressure: the receiver holds off while items keep coming, so the
		// result register fills and the input stalls
		send_idle_pct  = 0;
		take_stall_pct = 0;
		hold_left = 60;
		send_random(30, 60);
		wait_drained();

		// let the bench idle past the last result before the final check
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.failures == 0 && sb.due_results.size() == 0) begin
			$display("deque_with_value_delete_core test passed");
		end else begin
			if (sb.due_results.size() != 0)
				$display("%0d expected results never arrived", sb.due_results.size());
			$display("deque_with_value_delete_core test failed");
		end
		$finish;
	end

endmodule
